FILE: hdl/triangle_tone_envelope_generator_top_defines.svh
// Assertion macros shared by the tone generator modules.
`ifndef TRIANGLE_TONE_ENVELOPE_GENERATOR_TOP_DEFINES_SVH
`define TRIANGLE_TONE_ENVELOPE_GENERATOR_TOP_DEFINES_SVH

// Plain property, checked on every clock edge outside reset.
`define TTEG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define TTEG_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tteg_pkg.sv
// Shared types, constants and the note-to-increment table of the tone generator.
`timescale 1ns / 1ps
package tteg_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [13:0] NOTE_SAMPLES   = 14'd9000;
  localparam logic [13:0] LAST_INDEX     = 14'd8999;
  localparam logic [13:0] ATTACK_LEN     = 14'd4000;
  localparam logic [13:0] ATTACK_TOP     = 14'd8000;
  localparam logic [13:0] FADE_IN_LEN    = 14'd100;
  localparam logic [13:0] FADE_OUT_START = 14'd8000;
  localparam logic [13:0] TRI_PEAK       = 14'd8192;
  localparam logic [14:0] TRI_PERIOD     = 15'd16384;

  localparam int PROD_W  = 27;
  localparam int RECIP_W = 28;
  localparam int MULT_W  = PROD_W + RECIP_W;
  localparam int VAL_W   = 15;

  // Reciprocal constants: floor(p / d) == (p * ceil(2^s / d)) >> s for all p < 2^27.
  localparam int SHIFT_ATTACK   = 39;
  localparam int SHIFT_FADE_IN  = 34;
  localparam int SHIFT_FADE_OUT = 37;
  localparam logic [63:0] DIV_ATTACK   = 64'd4000;
  localparam logic [63:0] DIV_FADE_IN  = 64'd100;
  localparam logic [63:0] DIV_FADE_OUT = 64'd1000;
  localparam logic [RECIP_W-1:0] RECIP_ATTACK =
    RECIP_W'(((64'd1 << SHIFT_ATTACK) + DIV_ATTACK - 64'd1) / DIV_ATTACK);
  localparam logic [RECIP_W-1:0] RECIP_FADE_IN =
    RECIP_W'(((64'd1 << SHIFT_FADE_IN) + DIV_FADE_IN - 64'd1) / DIV_FADE_IN);
  localparam logic [RECIP_W-1:0] RECIP_FADE_OUT =
    RECIP_W'(((64'd1 << SHIFT_FADE_OUT) + DIV_FADE_OUT - 64'd1) / DIV_FADE_OUT);

  typedef enum logic [1:0] {
    STEP_ATTACK   = 2'd0,
    STEP_FADE_IN  = 2'd1,
    STEP_FADE_OUT = 2'd2
  } env_step_t;

  typedef struct packed {
    logic      start;
    logic      tick;
    logic      mul_factor;
    logic      mul_recip;
    env_step_t step;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic playing;
    logic attack;
    logic fade_in;
    logic fade_out;
    logic out_free;
  } dp_stat_t;

  // Phase increment for a note: semitone entry at 110 Hz, shifted up by octave.
  function automatic logic [31:0] note_step(input logic [5:0] note);
    logic [2:0]  octave;
    logic [5:0]  base;
    logic [3:0]  semi;
    logic [31:0] entry;
    if (note >= 6'd60)      octave = 3'd5;
    else if (note >= 6'd48) octave = 3'd4;
    else if (note >= 6'd36) octave = 3'd3;
    else if (note >= 6'd24) octave = 3'd2;
    else if (note >= 6'd12) octave = 3'd1;
    else                    octave = 3'd0;
    base = 6'({3'b000, octave} * 6'd12);
    semi = 4'(note - base);
    case (semi)
      4'd0:    entry = 32'd10713070;
      4'd1:    entry = 32'd11346115;
      4'd2:    entry = 32'd12027856;
      4'd3:    entry = 32'd12738815;
      4'd4:    entry = 32'd13498469;
      4'd5:    entry = 32'd14297079;
      4'd6:    entry = 32'd15154125;
      4'd7:    entry = 32'd16050127;
      4'd8:    entry = 32'd17004564;
      4'd9:    entry = 32'd18017437;
      4'd10:   entry = 32'd19088744;
      4'd11:   entry = 32'd20228225;
      default: entry = 32'd0;
    endcase
    return entry << octave;
  endfunction

endpackage

FILE: hdl/tteg_ctrl.sv
// Sequencer: accepts transfers and steps the envelope multiplies through the datapath.
`timescale 1ns / 1ps
`include "triangle_tone_envelope_generator_top_defines.svh"
module tteg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  tteg_pkg::dp_stat_t stat,
  output tteg_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ATK_F  = 8'b0000_0010,
    S_ATK_R  = 8'b0000_0100,
    S_FIN_F  = 8'b0000_1000,
    S_FIN_R  = 8'b0001_0000,
    S_FOUT_F = 8'b0010_0000,
    S_FOUT_R = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.step       = tteg_pkg::STEP_ATTACK;
    case (state)
      S_IDLE: begin
        if (accept && command == tteg_pkg::CMD_START) begin
          cmd.start = 1'b1;
        end else if (accept && stat.playing) begin
          cmd.tick = 1'b1;
          if (stat.attack)        state_next = S_ATK_F;
          else if (stat.fade_in)  state_next = S_FIN_F;
          else if (stat.fade_out) state_next = S_FOUT_F;
          else                    state_next = S_OUT;
        end
      end
      S_ATK_F: begin
        cmd.mul_factor = 1'b1;
        state_next     = S_ATK_R;
      end
      S_ATK_R: begin
        cmd.mul_recip = 1'b1;
        if (stat.fade_in)       state_next = S_FIN_F;
        else if (stat.fade_out) state_next = S_FOUT_F;
        else                    state_next = S_OUT;
      end
      S_FIN_F: begin
        cmd.mul_factor = 1'b1;
        cmd.step       = tteg_pkg::STEP_FADE_IN;
        state_next     = S_FIN_R;
      end
      S_FIN_R: begin
        cmd.mul_recip = 1'b1;
        cmd.step      = tteg_pkg::STEP_FADE_IN;
        state_next    = stat.fade_out ? S_FOUT_F : S_OUT;
      end
      S_FOUT_F: begin
        cmd.mul_factor = 1'b1;
        cmd.step       = tteg_pkg::STEP_FADE_OUT;
        state_next     = S_FOUT_R;
      end
      S_FOUT_R: begin
        cmd.mul_recip = 1'b1;
        cmd.step      = tteg_pkg::STEP_FADE_OUT;
        state_next    = S_OUT;
      end
      S_OUT: begin
        // wait here while an earlier result is still unclaimed
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `TTEG_ASSERT(a_state_onehot, $onehot(state), "sequencer state not one-hot")
  `TTEG_IMPLY(a_atk_pair, state == S_ATK_R, $past(state) == S_ATK_F, "attack divide without multiply")
  `TTEG_IMPLY(a_fout_pair, state == S_FOUT_R, $past(state) == S_FOUT_F, "fade-out divide without multiply")

endmodule

FILE: hdl/tteg_datapath.sv
// Phase accumulator, triangle fold, shared envelope multiplier and output register.
`timescale 1ns / 1ps
`include "triangle_tone_envelope_generator_top_defines.svh"
module tteg_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [5:0]                      note,
  input  tteg_pkg::dp_cmd_t               cmd,
  output tteg_pkg::dp_stat_t              stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tteg_pkg::VAL_W-1:0]      sample,
  output logic                            last_sample
);

  logic [31:0]                     phase_acc;
  logic [31:0]                     phase_step;
  logic [13:0]                     sample_index;
  logic                            playing;
  logic [tteg_pkg::VAL_W-1:0]      value;
  logic [tteg_pkg::PROD_W-1:0]     prod;

  logic [13:0]                     phase_frac;
  logic [tteg_pkg::VAL_W-1:0]      tri_val;
  logic [13:0]                     attack_f;
  logic [13:0]                     fade_out_f;
  logic [12:0]                     factor;
  logic [tteg_pkg::RECIP_W-1:0]    recip;
  logic [tteg_pkg::PROD_W-1:0]     mul_a;
  logic [tteg_pkg::RECIP_W-1:0]    mul_b;
  logic [tteg_pkg::MULT_W-1:0]     mult;
  logic [tteg_pkg::VAL_W-1:0]      quot;
  logic                            is_last;

  assign phase_frac = phase_acc[31:18];
  assign tri_val    = (phase_frac > tteg_pkg::TRI_PEAK)
                      ? tteg_pkg::TRI_PERIOD - {1'b0, phase_frac}
                      : {1'b0, phase_frac};

  assign attack_f   = tteg_pkg::ATTACK_TOP - sample_index;
  assign fade_out_f = tteg_pkg::NOTE_SAMPLES - sample_index;
  assign is_last    = (sample_index == tteg_pkg::LAST_INDEX);

  always_comb begin
    case (cmd.step)
      tteg_pkg::STEP_ATTACK: begin
        factor = attack_f[12:0];
        recip  = tteg_pkg::RECIP_ATTACK;
      end
      tteg_pkg::STEP_FADE_IN: begin
        factor = {6'd0, sample_index[6:0]};
        recip  = tteg_pkg::RECIP_FADE_IN;
      end
      tteg_pkg::STEP_FADE_OUT: begin
        factor = {3'd0, fade_out_f[9:0]};
        recip  = tteg_pkg::RECIP_FADE_OUT;
      end
      default: begin
        factor = '0;
        recip  = '0;
      end
    endcase
  end

  // One multiplier: value * factor, then product * reciprocal
  assign mul_a = cmd.mul_factor ? tteg_pkg::PROD_W'(value) : prod;
  assign mul_b = cmd.mul_factor ? tteg_pkg::RECIP_W'(factor) : recip;
  assign mult  = tteg_pkg::MULT_W'(mul_a) * tteg_pkg::MULT_W'(mul_b);

  always_comb begin
    case (cmd.step)
      tteg_pkg::STEP_ATTACK:   quot = mult[tteg_pkg::SHIFT_ATTACK +: tteg_pkg::VAL_W];
      tteg_pkg::STEP_FADE_IN:  quot = mult[tteg_pkg::SHIFT_FADE_IN +: tteg_pkg::VAL_W];
      tteg_pkg::STEP_FADE_OUT: quot = mult[tteg_pkg::SHIFT_FADE_OUT +: tteg_pkg::VAL_W];
      default:                 quot = '0;
    endcase
  end

  assign stat.playing  = playing;
  assign stat.attack   = (sample_index < tteg_pkg::ATTACK_LEN);
  assign stat.fade_in  = (sample_index < tteg_pkg::FADE_IN_LEN);
  assign stat.fade_out = (sample_index > tteg_pkg::FADE_OUT_START);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      phase_step   <= '0;
      sample_index <= '0;
      playing      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.start) begin
        phase_step   <= tteg_pkg::note_step(note);
        phase_acc    <= '0;
        sample_index <= '0;
        playing      <= 1'b1;
      end else if (cmd.out_load) begin
        phase_acc <= phase_acc + phase_step;
        if (is_last) begin
          playing      <= 1'b0;
          sample_index <= '0;
        end else begin
          sample_index <= sample_index + 14'd1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      value <= tri_val;
    end else if (cmd.mul_recip) begin
      value <= quot;
    end
    if (cmd.mul_factor) begin
      prod <= mult[tteg_pkg::PROD_W-1:0];
    end
    if (cmd.out_load) begin
      sample      <= value;
      last_sample <= is_last;
    end
  end

  `TTEG_ASSERT(a_index_range, sample_index < tteg_pkg::NOTE_SAMPLES, "sample index past note end")
  `TTEG_IMPLY(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "pending result overwritten")
  `TTEG_IMPLY(a_end_flagged, $fell(playing) && !$past(rst), out_valid && last_sample, "note ended without last sample")

endmodule

FILE: hdl/triangle_tone_envelope_generator_top.sv
// Top level of the triangle tone generator with attack, fade-in and fade-out envelope.
//
// Input channel (in_valid/in_ready, command, note): command 0 starts a note, taking
// its number from note; command 1 is one sample tick and note is ignored. A start
// and a tick while no note plays give no result.
// Output channel (out_valid/out_ready, sample, last_sample): one sample per tick
// while a note plays; last_sample marks the 9000th and final sample of the note.
// Each tick is folded from the phase accumulator, then runs through up to two
// envelope steps on one shared multiplier (product, then a reciprocal multiply that
// divides exactly); both the attack and fade-in steps are active for the first 100
// samples. The result is then loaded into the output register, and a new transfer
// is taken the cycle after the result is loaded. A start leaves the sequencer idle.
// When the receiver stalls, the held result stays in the output register while
// the next tick is still taken and processed; the sequencer then waits before the
// load step until the output register is free.
// Reset (rst, synchronous) returns to idle with no note playing and clears the
// phase, increment, sample index and output valid.
`timescale 1ns / 1ps
module triangle_tone_envelope_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [5:0]  note,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] sample,
  output logic        last_sample
);

  tteg_pkg::dp_cmd_t  cmd;
  tteg_pkg::dp_stat_t stat;

  tteg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  tteg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .note        (note),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample      (sample),
    .last_sample (last_sample)
  );

endmodule
